>>> hw/rtl/dtk_pkg.sv
`timescale 1ns / 1ps

package dtk_pkg;

  localparam int KEY_W   = 32;
  localparam int DELAY_W = 10;
  localparam int TICK_W  = 7;
  localparam int TIMER_W = 11;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 2;
  localparam int ODATA_W = 40;

  localparam logic [KEY_W-1:0]   KEY_LOW_MASK    = 32'h0000_0fff;
  localparam logic [DELAY_W-1:0] TAP_DELAY_RESET = 10'd200;
  localparam logic [TICK_W-1:0]  TICK_MS_RESET   = 7'd10;

  localparam logic [ADDR_W-1:0] CFG_TAP_DELAY = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_TICK_MS   = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_TYPE_MASK = 2'd2;
  localparam logic [ADDR_W-1:0] CFG_TYPE_CODE = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2
  } dtk_mode_t;

  typedef enum logic [1:0] {
    PH_WAIT_RELEASE = 2'd0,
    PH_WAIT_PRESS   = 2'd1,
    PH_DOUBLE       = 2'd2,
    PH_SINGLE       = 2'd3
  } dtk_phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ANSWER  = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_SUMMARY = 2'd3
  } dtk_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_WALK = 2'd2,
    ST_SUM  = 2'd3
  } dtk_state_t;

  typedef struct packed {
    logic capture;
    logic do_key;
    logic walk_clear;
    logic walk_step;
    logic emit_summary;
  } dtk_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              emit;
    logic              walk_last;
    logic              out_free;
  } dtk_sts_t;

endpackage

>>> hw/rtl/dtk_ctrl.sv
`timescale 1ns / 1ps

module dtk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dtk_pkg::dtk_sts_t sts,
  output dtk_pkg::dtk_cmd_t cmd
);

  dtk_pkg::dtk_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtk_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = dtk_pkg::ST_EXEC;
      end
      dtk_pkg::ST_EXEC: begin
        priority if (sts.mode == dtk_pkg::MODE_TICK) begin
          state_nxt = dtk_pkg::ST_WALK;
        end else if (sts.mode == dtk_pkg::MODE_PRESS || sts.mode == dtk_pkg::MODE_RELEASE) begin
          if (sts.out_free) state_nxt = dtk_pkg::ST_IDLE;
        end else begin
          state_nxt = dtk_pkg::ST_IDLE;
        end
      end
      dtk_pkg::ST_WALK: begin
        if ((!sts.emit || sts.out_free) && sts.walk_last) state_nxt = dtk_pkg::ST_SUM;
      end
      dtk_pkg::ST_SUM: begin
        if (sts.out_free) state_nxt = dtk_pkg::ST_IDLE;
      end
      default: state_nxt = dtk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dtk_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      dtk_pkg::ST_EXEC: begin
        cmd.walk_clear = (sts.mode == dtk_pkg::MODE_TICK);
        cmd.do_key     = (sts.mode == dtk_pkg::MODE_PRESS || sts.mode == dtk_pkg::MODE_RELEASE)
                         && sts.out_free;
      end
      dtk_pkg::ST_WALK: begin
        cmd.walk_step = !sts.emit || sts.out_free;
      end
      dtk_pkg::ST_SUM: begin
        cmd.emit_summary = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/dtk_datapath.sv
`timescale 1ns / 1ps

module dtk_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dtk_pkg::KEY_W-1:0]         in_key,
  input  logic [dtk_pkg::MODE_W-1:0]        in_mode,
  input  logic                              cfg_we,
  input  logic [dtk_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [dtk_pkg::KEY_W-1:0]         cfg_wdata,
  input  dtk_pkg::dtk_cmd_t                 cmd,
  output dtk_pkg::dtk_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dtk_pkg::KIND_W-1:0]        out_kind,
  output logic [dtk_pkg::KEY_W-1:0]         out_key,
  output logic                              out_claimed,
  output logic                              out_pending,
  output logic                              out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [dtk_pkg::DELAY_W-1:0] tap_delay_r;
  logic [dtk_pkg::TICK_W-1:0]  tick_ms_r;
  logic [dtk_pkg::KEY_W-1:0]   type_mask_r;
  logic [dtk_pkg::KEY_W-1:0]   type_code_r;

  logic [dtk_pkg::MODE_W-1:0] mode_r;
  logic [dtk_pkg::KEY_W-1:0]  key_r;

  logic [SLOTS-1:0]            used_r;
  dtk_pkg::dtk_phase_t         phase_r [SLOTS];
  logic [dtk_pkg::KEY_W-1:0]   skey_r  [SLOTS];
  logic [dtk_pkg::TIMER_W-1:0] timer_r [SLOTS];

  logic [IDX_W-1:0] idx_r;
  logic             pend_r;

  logic                        out_valid_r;
  logic [dtk_pkg::KIND_W-1:0]  kind_r;
  logic [dtk_pkg::KEY_W-1:0]   okey_r;
  logic                        claimed_r;
  logic                        pending_r;
  logic                        last_r;

  logic                out_free;
  logic                is_dt;
  logic [SLOTS-1:0]    match_v;
  logic [SLOTS-1:0]    free_v;
  logic [SLOTS-1:0]    free_oh;
  logic                hit;
  logic [1:0]          hit_ph;
  logic                is_press;
  logic                is_release;
  logic                alloc;
  logic                to_double;
  logic                to_wait_press;
  logic                rel_free;
  logic                claimed_c;

  logic                        w_used;
  dtk_pkg::dtk_phase_t         w_ph;
  dtk_pkg::dtk_phase_t         w_new_ph;
  logic [dtk_pkg::TIMER_W-1:0] w_sum;
  logic [dtk_pkg::TIMER_W-1:0] w_new_t;
  logic                        w_expire;
  logic                        w_drop;
  logic                        w_emit;

  assign out_free = !out_valid_r || out_ready;

  // cfg registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_delay_r <= dtk_pkg::TAP_DELAY_RESET;
      tick_ms_r   <= dtk_pkg::TICK_MS_RESET;
      type_mask_r <= '0;
      type_code_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dtk_pkg::CFG_TAP_DELAY: tap_delay_r <= cfg_wdata[dtk_pkg::DELAY_W-1:0];
        dtk_pkg::CFG_TICK_MS:   tick_ms_r   <= cfg_wdata[dtk_pkg::TICK_W-1:0];
        dtk_pkg::CFG_TYPE_MASK: type_mask_r <= cfg_wdata;
        dtk_pkg::CFG_TYPE_CODE: type_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
  end

  // press / release decode
  always_comb begin
    is_dt  = (key_r & type_mask_r) == type_code_r;
    hit_ph = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_v[i] = used_r[i] && (skey_r[i] == key_r);
      free_v[i]  = !used_r[i];
      hit_ph     = hit_ph | (phase_r[i] & {2{match_v[i]}});
    end
    free_oh       = free_v & (~free_v + SLOTS'(1));
    hit           = |match_v;
    is_press      = (mode_r == dtk_pkg::MODE_PRESS);
    is_release    = (mode_r == dtk_pkg::MODE_RELEASE);
    alloc         = is_press && is_dt && !hit;
    to_double     = is_press && is_dt && hit && (hit_ph == dtk_pkg::PH_WAIT_PRESS);
    to_wait_press = is_release && is_dt && hit && (hit_ph == dtk_pkg::PH_WAIT_RELEASE);
    rel_free      = is_release && is_dt && hit &&
                    (hit_ph == dtk_pkg::PH_DOUBLE || hit_ph == dtk_pkg::PH_SINGLE);
    claimed_c     = alloc || to_double || to_wait_press;
  end

  // tick walk, one slot per step
  always_comb begin
    w_used   = used_r[idx_r];
    w_ph     = phase_r[idx_r];
    w_sum    = timer_r[idx_r] + dtk_pkg::TIMER_W'(tick_ms_r);
    w_expire = w_sum >= dtk_pkg::TIMER_W'(tap_delay_r);
    w_new_t  = w_expire ? dtk_pkg::TIMER_W'(tap_delay_r) : w_sum;
    w_new_ph = (w_expire && w_ph != dtk_pkg::PH_DOUBLE) ? dtk_pkg::PH_SINGLE : w_ph;
    w_drop   = w_expire && (w_ph == dtk_pkg::PH_WAIT_PRESS);
    w_emit   = w_used && (w_new_ph == dtk_pkg::PH_SINGLE || w_new_ph == dtk_pkg::PH_DOUBLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < SLOTS; i++) phase_r[i] <= dtk_pkg::PH_WAIT_RELEASE;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd.do_key) begin
          if (alloc && free_oh[i]) begin
            used_r[i]  <= 1'b1;
            phase_r[i] <= dtk_pkg::PH_WAIT_RELEASE;
          end
          if (to_double && match_v[i])     phase_r[i] <= dtk_pkg::PH_DOUBLE;
          if (to_wait_press && match_v[i]) phase_r[i] <= dtk_pkg::PH_WAIT_PRESS;
          if (rel_free && match_v[i])      used_r[i]  <= 1'b0;
        end
        if (cmd.walk_step && w_used && idx_r == IDX_W'(i)) begin
          phase_r[i] <= w_new_ph;
          if (w_drop) used_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.do_key && alloc && free_oh[i]) begin
        skey_r[i]  <= key_r;
        timer_r[i] <= '0;
      end
      if (cmd.walk_step && w_used && idx_r == IDX_W'(i)) begin
        timer_r[i] <= w_new_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.walk_clear) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.walk_step) begin
      idx_r  <= idx_r + IDX_W'(1);
      pend_r <= pend_r || (w_used && !w_expire);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_key || cmd.emit_summary || (cmd.walk_step && w_emit)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_key) begin
      kind_r    <= dtk_pkg::KIND_ANSWER;
      okey_r    <= '0;
      claimed_r <= claimed_c;
      pending_r <= 1'b0;
      last_r    <= 1'b1;
    end else if (cmd.emit_summary) begin
      kind_r    <= dtk_pkg::KIND_SUMMARY;
      okey_r    <= '0;
      claimed_r <= 1'b0;
      pending_r <= pend_r;
      last_r    <= 1'b1;
    end else if (cmd.walk_step && w_emit) begin
      if (w_new_ph == dtk_pkg::PH_SINGLE) begin
        kind_r <= dtk_pkg::KIND_SINGLE;
        okey_r <= skey_r[idx_r] & dtk_pkg::KEY_LOW_MASK;
      end else begin
        kind_r <= dtk_pkg::KIND_DOUBLE;
        okey_r <= skey_r[idx_r];
      end
      claimed_r <= 1'b0;
      pending_r <= 1'b0;
      last_r    <= 1'b0;
    end
  end

  assign sts.mode      = mode_r;
  assign sts.emit      = w_emit;
  assign sts.walk_last = (idx_r == IDX_W'(SLOTS - 1));
  assign sts.out_free  = out_free;

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_key     = okey_r;
  assign out_claimed = claimed_r;
  assign out_pending = pending_r;
  assign out_last    = last_r;

endmodule

>>> hw/rtl/double_tap_key_detector_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                        Contents
// in       in   in_tvalid/tready/tdata/tuser   tdata: key_word; tuser: mode
// out      out  out_tvalid/tready/tdata/tuser  tdata: key_out, claimed, pending;
//                 /tlast                       tuser: kind; tlast: last
// cfg      in   cfg_we/addr/wdata              register write, no read-back
//
// One word at a time. Press/release: EXEC waits for a free output register, then registers
// the answer. Tick: walk_clear, slot walk (one slot per cycle while the output is free or
// the slot does not emit), summary. A new word is accepted while the last result still sits
// in the output register. Output stalls hold the walk only on slots that emit. Sync reset
// clears slot occupancy, phases, config, walk state and output valid; no clearing pass.

module double_tap_key_detector_unit #(
  parameter int SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dtk_pkg::KEY_W-1:0]     in_tdata,   // [31:0] key_word
  input  logic [dtk_pkg::MODE_W-1:0]    in_tuser,   // [1:0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dtk_pkg::ODATA_W-1:0]   out_tdata,  // [31:0] key_out, [32] claimed,
                                                    // [33] pending, [39:34] zero
  output logic [dtk_pkg::KIND_W-1:0]    out_tuser,  // [1:0] kind
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [dtk_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [dtk_pkg::KEY_W-1:0]     cfg_wdata
);

  dtk_pkg::dtk_cmd_t cmd;
  dtk_pkg::dtk_sts_t sts;

  logic [dtk_pkg::KEY_W-1:0] out_key;
  logic                      out_claimed;
  logic                      out_pending;

  dtk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtk_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key      (in_tdata),
    .in_mode     (in_tuser),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_tuser),
    .out_key     (out_key),
    .out_claimed (out_claimed),
    .out_pending (out_pending),
    .out_last    (out_tlast)
  );

  assign out_tdata = {6'b0, out_pending, out_claimed, out_key};

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.do_key || cmd.walk_step || cmd.emit_summary || cmd.walk_clear))
    else $error("input ready while a word is in work");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.do_key, cmd.walk_clear, cmd.walk_step, cmd.emit_summary}))
    else $error("more than one datapath action in a cycle");

  a_key_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_key |=> out_tvalid && out_tlast && out_tuser == dtk_pkg::KIND_ANSWER)
    else $error("press/release answer not presented");

  a_summary_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_summary |=> out_tvalid && out_tlast && out_tuser == dtk_pkg::KIND_SUMMARY)
    else $error("tick summary not presented");
`endif

endmodule
